[rtl/tbd_pkg.sv]
// Shared types and constants for the truncated boundary distance block.
package tbd_pkg;

	localparam int DIST_W = 10;
	localparam int DIM_W  = 9;
	localparam int SQ_W   = 2 * DIST_W;

	localparam logic [1:0] FN_LOAD    = 2'd0;
	localparam logic [1:0] FN_COMPUTE = 2'd1;
	localparam logic [1:0] FN_READ    = 2'd2;

	localparam logic KIND_COMPUTE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_CAP  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_CAPSQ,
		S_INIT_RD,
		S_INIT_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_NB_RD,
		S_NB_CHK,
		S_WIN_RD,
		S_MUL1,
		S_MUL2,
		S_CMP,
		S_SQRT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DIM_W-1:0]  cols;
		logic [DIM_W-1:0]  rows;
		logic [DIST_W-1:0] cap;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [DIST_W-1:0] dval;
	} result_t;

endpackage

[rtl/tbd_regs.sv]
// Configuration register file behind the APB-style port.
module tbd_regs
	import tbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= DIM_W'(256);
			cfg_q.rows <= DIM_W'(256);
			cfg_q.cap  <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_COLS: cfg_q.cols <= pwdata[DIM_W-1:0];
				REG_ROWS: cfg_q.rows <= pwdata[DIM_W-1:0];
				REG_CAP:  cfg_q.cap  <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COLS: prdata = 32'(cfg_q.cols);
			REG_ROWS: prdata = 32'(cfg_q.rows);
			REG_CAP:  prdata = 32'(cfg_q.cap);
			default:  prdata = '0;
		endcase
	end

endmodule

[rtl/tbd_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module tbd_sqrt
	import tbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [DIST_W-1:0] root
);

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q;
	logic            done_q;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

[rtl/tbd_engine.sv]
// Sequencer, pixel memories and shared multiplier for load, compute and read.
module tbd_engine
	import tbd_pkg::*;
#(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int FRAC_BITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       start,
	input  logic [1:0] func,
	input  logic [7:0] pixel_col,
	input  logic [7:0] pixel_row,
	input  logic       pixel_valid,
	output logic       busy,
	output result_t    res
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;
	localparam int MW = (CW > RW) ? CW : RW;
	localparam int UW = (MW > DIST_W) ? MW : DIST_W;
	localparam int PW = 2 * UW;
	localparam int SW = PW + 1 + 2 * FRAC_BITS;
	localparam int XW = UW + 2;

	state_t state_q, state_d;

	logic [DIST_W-1:0] dmem [2**AW];
	logic              vmem [2**AW];

	logic [CW-1:0] x_q, c_q, clo_q, chi_q;
	logic [RW-1:0] y_q, r_q, rhi_q;
	logic [DIST_W-1:0] rd_q;
	logic              vrd_q;
	logic              in_store_q;
	logic [MW-1:0] dc_q, dr_q;
	logic [SQ_W-1:0] cap_sq_q;
	logic [PW-1:0]   prod_q;
	logic [PW:0]     dsq_q;

	logic [CW:0]   cols_eff;
	logic [RW:0]   rows_eff;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic [DIST_W:0]   cap_rnd;
	logic [DIST_W-1:0] reach, rad;
	logic signed [XW-1:0] ylo_s, yhi_s, xlo_s, xhi_s;
	logic [CW-1:0] clo_n, chi_n;
	logic [RW-1:0] rlo_n, rhi_n;
	logic pix_last, win_last, inner, in_store;
	logic [SW-1:0] scaled;
	logic in_range;

	logic [UW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_p;

	logic              dre, dwe, vwe, vre;
	logic [AW-1:0]     draddr, dwaddr;
	logic [DIST_W-1:0] dwdata;
	logic              pix_clr, pix_adv, bnd_ld, win_step, sq_start;

	logic              sq_done;
	logic [DIST_W-1:0] sq_root;

	always_comb begin
		if (cfg.cols == '0) begin
			cols_eff = (CW+1)'(1);
		end else if (32'(cfg.cols) > MAX_COLS) begin
			cols_eff = (CW+1)'(MAX_COLS);
		end else begin
			cols_eff = (CW+1)'(cfg.cols);
		end
		if (cfg.rows == '0) begin
			rows_eff = (RW+1)'(1);
		end else if (32'(cfg.rows) > MAX_ROWS) begin
			rows_eff = (RW+1)'(MAX_ROWS);
		end else begin
			rows_eff = (RW+1)'(cfg.rows);
		end
	end

	assign col_last = CW'(cols_eff - (CW+1)'(1));
	assign row_last = RW'(rows_eff - (RW+1)'(1));
	assign cap_rnd  = {1'b0, cfg.cap} + (DIST_W+1)'((1 << FRAC_BITS) - 1);
	assign reach    = DIST_W'(cap_rnd >> FRAC_BITS);
	assign rad      = (state_q == S_SCAN_CHK) ? DIST_W'(1) : reach;

	assign ylo_s = $signed(XW'(y_q)) - $signed(XW'(rad));
	assign yhi_s = $signed(XW'(y_q)) + $signed(XW'(rad));
	assign xlo_s = $signed(XW'(x_q)) - $signed(XW'(rad));
	assign xhi_s = $signed(XW'(x_q)) + $signed(XW'(rad));
	assign rlo_n = (ylo_s < 0) ? '0 : RW'(ylo_s);
	assign clo_n = (xlo_s < 0) ? '0 : CW'(xlo_s);
	assign rhi_n = (yhi_s > $signed(XW'(row_last))) ? row_last : RW'(yhi_s);
	assign chi_n = (xhi_s > $signed(XW'(col_last))) ? col_last : CW'(xhi_s);

	assign pix_last = (x_q == col_last) && (y_q == row_last);
	assign win_last = (c_q == chi_q) && (r_q == rhi_q);
	assign inner    = (x_q != '0) && (x_q != col_last) && (y_q != '0) && (y_q != row_last);
	assign in_store = (32'(pixel_col) < MAX_COLS) && (32'(pixel_row) < MAX_ROWS);
	assign scaled   = SW'(dsq_q) << (2 * FRAC_BITS);
	assign in_range = scaled < SW'(cap_sq_q);
	assign mul_p    = mul_a * mul_b;
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && func == FN_COMPUTE) begin
					state_d = S_CAPSQ;
				end else if (start && func == FN_READ) begin
					state_d = S_READ;
				end
			end
			S_READ:    state_d = S_IDLE;
			S_CAPSQ:   state_d = S_INIT_RD;
			S_INIT_RD: state_d = S_INIT_WR;
			S_INIT_WR: state_d = pix_last ? S_SCAN_RD : S_INIT_RD;
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (rd_q == '0) begin
					state_d = S_NB_RD;
				end else begin
					state_d = pix_last ? S_DONE : S_SCAN_RD;
				end
			end
			S_NB_RD: state_d = S_NB_CHK;
			S_NB_CHK: begin
				if (rd_q != '0) begin
					state_d = S_WIN_RD;
				end else if (!win_last) begin
					state_d = S_NB_RD;
				end else begin
					state_d = pix_last ? S_DONE : S_SCAN_RD;
				end
			end
			S_WIN_RD: state_d = S_MUL1;
			S_MUL1: begin
				if (rd_q != '0) begin
					state_d = S_MUL2;
				end else if (!win_last) begin
					state_d = S_WIN_RD;
				end else begin
					state_d = pix_last ? S_DONE : S_SCAN_RD;
				end
			end
			S_MUL2: state_d = S_CMP;
			S_CMP: begin
				if (in_range) begin
					state_d = S_SQRT;
				end else if (!win_last) begin
					state_d = S_WIN_RD;
				end else begin
					state_d = pix_last ? S_DONE : S_SCAN_RD;
				end
			end
			S_SQRT: begin
				if (sq_done) begin
					if (!win_last) begin
						state_d = S_WIN_RD;
					end else begin
						state_d = pix_last ? S_DONE : S_SCAN_RD;
					end
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		dre       = 1'b0;
		vre       = 1'b0;
		vwe       = 1'b0;
		dwe       = 1'b0;
		draddr    = {r_q, c_q};
		dwaddr    = {r_q, c_q};
		dwdata    = sq_root;
		mul_a     = UW'(dc_q);
		mul_b     = UW'(dc_q);
		pix_clr   = 1'b0;
		pix_adv   = 1'b0;
		bnd_ld    = 1'b0;
		win_step  = 1'b0;
		sq_start  = 1'b0;
		res.valid = 1'b0;
		res.kind  = KIND_COMPUTE;
		res.dval  = '0;
		unique case (state_q)
			S_IDLE: begin
				draddr  = {RW'(pixel_row), CW'(pixel_col)};
				vwe     = start && func == FN_LOAD && in_store;
				dre     = start && func == FN_READ;
				pix_clr = start && func == FN_COMPUTE;
			end
			S_READ: begin
				res.valid = 1'b1;
				res.kind  = KIND_READ;
				res.dval  = in_store_q ? rd_q : '0;
			end
			S_CAPSQ: begin
				mul_a = UW'(cfg.cap);
				mul_b = UW'(cfg.cap);
			end
			S_INIT_RD: vre = 1'b1;
			S_INIT_WR: begin
				dwe     = 1'b1;
				dwaddr  = {y_q, x_q};
				dwdata  = (vrd_q && inner) ? cfg.cap : '0;
				pix_adv = 1'b1;
			end
			S_SCAN_RD: begin
				dre    = 1'b1;
				draddr = {y_q, x_q};
			end
			S_SCAN_CHK: begin
				bnd_ld  = (rd_q == '0);
				pix_adv = (rd_q != '0);
			end
			S_NB_RD: dre = 1'b1;
			S_NB_CHK: begin
				bnd_ld   = (rd_q != '0);
				win_step = (rd_q == '0) && !win_last;
				pix_adv  = (rd_q == '0) && win_last;
			end
			S_WIN_RD: dre = 1'b1;
			S_MUL1: begin
				win_step = (rd_q == '0) && !win_last;
				pix_adv  = (rd_q == '0) && win_last;
			end
			S_MUL2: begin
				mul_a = UW'(dr_q);
				mul_b = UW'(dr_q);
			end
			S_CMP: begin
				sq_start = in_range;
				win_step = !in_range && !win_last;
				pix_adv  = !in_range && win_last;
			end
			S_SQRT: begin
				dwe      = sq_done && (sq_root < rd_q);
				win_step = sq_done && !win_last;
				pix_adv  = sq_done && win_last;
			end
			S_DONE: begin
				res.valid = 1'b1;
				res.kind  = KIND_COMPUTE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[{RW'(pixel_row), CW'(pixel_col)}] <= pixel_valid;
		end
		if (vre) begin
			vrd_q <= vmem[{y_q, x_q}];
		end
		if (dwe) begin
			dmem[dwaddr] <= dwdata;
		end
		if (dre) begin
			rd_q <= dmem[draddr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			in_store_q <= in_store;
		end
		if (state_q == S_CAPSQ) begin
			cap_sq_q <= SQ_W'(mul_p);
		end
		if (state_q == S_MUL1) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MUL2) begin
			dsq_q <= (PW+1)'(prod_q) + (PW+1)'(mul_p);
		end
		if (state_q == S_WIN_RD) begin
			dc_q <= MW'((c_q > x_q) ? (c_q - x_q) : (x_q - c_q));
			dr_q <= MW'((r_q > y_q) ? (r_q - y_q) : (y_q - r_q));
		end
		if (pix_clr) begin
			x_q <= '0;
			y_q <= '0;
		end else if (pix_adv) begin
			if (x_q == col_last) begin
				x_q <= '0;
				y_q <= (y_q == row_last) ? '0 : y_q + RW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
		if (bnd_ld) begin
			rhi_q <= rhi_n;
			clo_q <= clo_n;
			chi_q <= chi_n;
			r_q   <= rlo_n;
			c_q   <= clo_n;
		end else if (win_step) begin
			if (c_q == chi_q) begin
				c_q <= clo_q;
				r_q <= r_q + RW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	tbd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (SQ_W'(scaled)),
		.done     (sq_done),
		.root     (sq_root)
	);

endmodule

[rtl/truncated_boundary_distance.sv]
// Top level: register port, compute engine and result register.
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid / in_stall | func, pixel_col, pixel_row, pixel_valid
//  out     | out of    | out_valid/out_stall | reply_kind, distance
//  cfg     | into      | APB psel/penable    | paddr, pwdata, prdata
//
// A load only writes the valid map; a read fetches the stored distance, which S_READ
// hands to the output register. A compute squares the cap, seeds then scans every pixel,
// reads neighbors of a zero pixel and, for each window cell of a boundary pixel, skips a
// zero cell, rejects one out of reach or takes a root, then replies; the single distance
// read port and the bit-serial square root set its pace. in_stall is high while a
// transaction is in progress or a result waits. Reset clears control, not memories.
module truncated_boundary_distance
	import tbd_pkg::*;
#(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int FRAC_BITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [7:0]        pixel_col,
	input  logic [7:0]        pixel_row,
	input  logic              pixel_valid,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              reply_kind,
	output logic [DIST_W-1:0] distance,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg;
	result_t eng_res;
	logic    eng_busy;
	logic    start;
	logic    out_valid_q;
	logic    kind_q;
	logic [DIST_W-1:0] dist_q;

	assign in_stall   = eng_busy || out_valid_q;
	assign start      = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign reply_kind = kind_q;
	assign distance   = dist_q;

	tbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tbd_engine #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.start       (start),
		.func        (func),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.pixel_valid (pixel_valid),
		.busy        (eng_busy),
		.res         (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res.valid) begin
			kind_q <= eng_res.kind;
			dist_q <= eng_res.dval;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		eng_res.valid |-> !out_valid_q)
		else $error("result arrived while output register full");

	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(start && func == FN_COMPUTE) |=> in_stall)
		else $error("input taken during compute");

	a_compute_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reply_kind == KIND_COMPUTE) |-> distance == '0)
		else $error("compute reply carries nonzero distance");

endmodule

[bench/tb_truncated_boundary_distance.sv]
// Testbench for truncated_boundary_distance: random loads, computes and reads checked against a predictor.
`timescale 1ns / 100ps

module tb_truncated_boundary_distance
	import tbd_pkg::*;
();

	localparam logic [1:0] FN_NONE = 2'd3;
	localparam int NPIX = 65536;
	localparam int IDLE_LIMIT = 400000;

	typedef struct {
		logic              kind;
		logic [DIST_W-1:0] dval;
	} reply_t;

	class distance_scoreboard;
		bit                vmap[NPIX];
		logic [DIST_W-1:0] dstore[NPIX];
		bit                dknown[NPIX];
		int                known_q[$];
		reply_t            replies[$];
		int                cols = 256;
		int                rows = 256;
		int                cap;
		int                fails;

		function int clamp_dim(int v);
			if (v < 1) return 1;
			if (v > 256) return 256;
			return v;
		endfunction

		function int root_floor(longint v);
			int r = 0;
			for (int b = 9; b >= 0; b--) begin
				if (longint'(r + (1 << b)) * (r + (1 << b)) <= v) r += 1 << b;
			end
			return r;
		endfunction

		function void sweep();
			int c = clamp_dim(cols);
			int r = clamp_dim(rows);
			int reach = (cap + 15) >> 4;
			longint cap_sq = longint'(cap) * cap;
			bit edge_px;
			bit bnd;
			int i;
			longint dsq;
			int d;
			for (int y = 0; y < r; y++)
				for (int x = 0; x < c; x++) begin
					i = y * 256 + x;
					edge_px = !(x > 0 && x < c - 1 && y > 0 && y < r - 1);
					dstore[i] = (vmap[i] && !edge_px) ? DIST_W'(cap) : '0;
					if (!dknown[i]) begin
						dknown[i] = 1;
						known_q = {known_q, i};
					end
				end
			for (int y = 0; y < r; y++)
				for (int x = 0; x < c; x++) begin
					if (dstore[y * 256 + x] != 0) continue;
					bnd = 0;
					for (int rr = y - 1; rr <= y + 1; rr++)
						for (int cc = x - 1; cc <= x + 1; cc++)
							if (cc >= 0 && cc < c && rr >= 0 && rr < r &&
							    dstore[rr * 256 + cc] != 0) bnd = 1;
					if (!bnd) continue;
					for (int rr = y - reach; rr <= y + reach; rr++) begin
						if (rr < 0 || rr >= r) continue;
						for (int cc = x - reach; cc <= x + reach; cc++) begin
							if (cc < 0 || cc >= c) continue;
							i = rr * 256 + cc;
							if (dstore[i] == 0) continue;
							dsq = longint'((cc - x) * (cc - x) + (rr - y) * (rr - y)) << 8;
							if (dsq >= cap_sq) continue;
							d = root_floor(dsq);
							if (d < dstore[i]) dstore[i] = DIST_W'(d);
						end
					end
				end
		endfunction

		function void note(logic [1:0] f, int col, int row, bit v);
			reply_t rp;
			case (f)
				FN_LOAD: vmap[row * 256 + col] = v;
				FN_COMPUTE: begin
					sweep();
					rp.kind = KIND_COMPUTE;
					rp.dval = '0;
					replies = {replies, rp};
				end
				FN_READ: begin
					rp.kind = KIND_READ;
					rp.dval = dstore[row * 256 + col];
					replies = {replies, rp};
				end
				default: ;
			endcase
		endfunction

		function void check(logic kind, logic [DIST_W-1:0] dval);
			reply_t rp;
			if (replies.size() == 0) begin
				$error("unexpected reply kind=%0d distance=%0d", kind, dval);
				fails++;
				return;
			end
			rp = replies.pop_front();
			if (kind !== rp.kind) begin
				$error("reply_kind expected %0d actual %0d", rp.kind, kind);
				fails++;
			end
			if (dval !== rp.dval) begin
				$error("distance expected %0d actual %0d", rp.dval, dval);
				fails++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [1:0]        func = FN_LOAD;
	logic [7:0]        pixel_col = 0;
	logic [7:0]        pixel_row = 0;
	logic              pixel_valid = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic              reply_kind;
	logic [DIST_W-1:0] distance;
	logic              psel = 0;
	logic              penable = 0;
	logic              pwrite = 0;
	logic [3:0]        paddr = 0;
	logic [31:0]       pwdata = 0;
	logic [31:0]       prdata;
	logic              pready;

	distance_scoreboard sb = new();
	bit send_calm;
	bit recv_calm;
	int recv_left;
	int results;
	int idle_cycles;
	int counted;

	truncated_boundary_distance dut (.*);

	always #1 clk = ~clk;

	function automatic int draw_gap(ref bit calm);
		if ($urandom_range(0, 15) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check(reply_kind, distance);
				results++;
				recv_left = (results == 10) ? 300 : draw_gap(recv_calm);
			end else if (recv_left > 0) begin
				recv_left--;
			end
			out_stall <= recv_left > 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send(logic [1:0] f, int col, int row, bit v);
		int g = draw_gap(send_calm);
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		pixel_col <= col[7:0];
		pixel_row <= row[7:0];
		pixel_valid <= v;
		do @(posedge clk); while (in_stall);
		sb.note(f, col, row, v);
		if (f != FN_NONE) counted++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic setup_image(int c, int r, int cap);
		drain();
		reg_write(REG_COLS, c);
		reg_write(REG_ROWS, r);
		reg_write(REG_CAP, cap);
		sb.cols = c;
		sb.rows = r;
		sb.cap = cap;
		for (int y = 0; y < sb.clamp_dim(r); y++)
			for (int x = 0; x < sb.clamp_dim(c); x++)
				send(FN_LOAD, x, y, $urandom_range(0, 3) != 0);
	endtask

	task automatic read_some(int n);
		int i;
		int c = sb.clamp_dim(sb.cols);
		int r = sb.clamp_dim(sb.rows);
		repeat (n) begin
			i = $urandom_range(0, r - 1) * 256 + $urandom_range(0, c - 1);
			if (!sb.dknown[i] || $urandom_range(0, 3) == 0)
				i = sb.known_q[$urandom_range(0, sb.known_q.size() - 1)];
			send(FN_READ, i % 256, i / 256, 0);
		end
	endtask

	initial begin
		int pick;
		int c;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		setup_image(1, 1, 0);
		send(FN_LOAD, 255, 255, 1);
		send(FN_COMPUTE, 0, 0, 0);
		send(FN_NONE, 170, 85, 1);
		read_some(1);
		drain();
		reg_write(REG_COLS, 3);
		reg_write(REG_ROWS, 3);
		reg_write(REG_CAP, 1023);
		sb.cols = 3;
		sb.rows = 3;
		sb.cap = 1023;
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 3; x++) send(FN_LOAD, x, y, 1);
		send(FN_COMPUTE, 0, 0, 0);
		send(FN_READ, 1, 1, 0);
		send(FN_READ, 2, 2, 0);

		setup_image(0, 0, 5);
		send(FN_COMPUTE, 0, 0, 0);
		read_some(3);

		while (counted < 140) begin
			c = $urandom_range(2, 6);
			r = $urandom_range(2, 6);
			pick = $urandom_range(0, 4);
			setup_image(c, r, pick == 0 ? 1023 : pick == 1 ? 0 : $urandom_range(1, 1022));
			send(FN_COMPUTE, 0, 0, 0);
			repeat (15) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) read_some(1);
				else if (pick < 85) begin
					if ($urandom_range(0, 9) == 0)
						send(FN_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
							$urandom_range(0, 1));
					else
						send(FN_LOAD, $urandom_range(0, c - 1), $urandom_range(0, r - 1),
							$urandom_range(0, 1));
				end else if (pick < 92) send(FN_COMPUTE, 0, 0, 0);
				else send(FN_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 1));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.replies.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

[truncated_boundary_distance.f]
rtl/tbd_pkg.sv
rtl/tbd_regs.sv
rtl/tbd_sqrt.sv
rtl/tbd_engine.sv
rtl/truncated_boundary_distance.sv
bench/tb_truncated_boundary_distance.sv
